// File: rtl/sstd_pkg.sv
package sstd_pkg;

    // Display geometry and field widths
    localparam int NUM_POS = 5;
    localparam int POS_W   = 3;
    localparam int SEG_W   = 8;
    localparam int SEL_W   = 5;
    localparam int CODE_W  = 8;
    localparam int MAG_W   = 14;
    localparam int DIG_W   = 4;
    localparam int NUM_DIG = 4;
    localparam int MAX_W   = 14;
    localparam int MIN_W   = 11;
    localparam int TEMP_W  = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // Glyph codes used by the temperature layout
    localparam logic [CODE_W-1:0] GLYPH_BLANK = 8'h10;
    localparam logic [CODE_W-1:0] GLYPH_MINUS = 8'h11;
    localparam logic [CODE_W-1:0] DOT_FLAG    = 8'h80;

    // Shown range limits in tenths
    localparam logic [MAX_W-1:0]        SHOW_MAX_LIMIT = 14'd9999;
    localparam logic signed [MIN_W-1:0] SHOW_MIN_LIMIT = -11'sd999;

    // Reciprocal of ten scaled by 2^16, rounded down
    localparam logic [12:0] RECIP_TEN   = 13'd6553;
    localparam int          RECIP_SHIFT = 16;

    // Register map
    localparam logic REG_MAX_SHOWN = 1'b0;
    localparam logic REG_MIN_SHOWN = 1'b1;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_TEMP  = 2'd1,
        REQ_GLYPH = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [CODE_W-1:0] code;
    } t_chan;

    // One classified request travelling from front to back
    typedef struct packed {
        t_req              kind;
        logic              chan_ok;
        logic [SEG_W-1:0]  chan_seg;
        logic              oor;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [POS_W-1:0]  pos;
        logic [SEG_W-1:0]  glyph_seg;
    } t_entry;

    function automatic logic [SEG_W-1:0] glyph_segments(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] seg;
        unique case (code)
            8'h00: seg = 8'h3f;
            8'h01: seg = 8'h06;
            8'h02: seg = 8'h5b;
            8'h03: seg = 8'h4f;
            8'h04: seg = 8'h66;
            8'h05: seg = 8'h6d;
            8'h06: seg = 8'h7d;
            8'h07: seg = 8'h07;
            8'h08: seg = 8'h7f;
            8'h09: seg = 8'h6f;
            8'h0a: seg = 8'h77;
            8'h0b: seg = 8'h7c;
            8'h0c: seg = 8'h39;
            8'h0d: seg = 8'h73;
            8'h0e: seg = 8'h71;
            8'h0f: seg = 8'h79;
            8'h10: seg = 8'h00;
            8'h11: seg = 8'h40;
            8'h12: seg = 8'h50;
            8'h13: seg = 8'h5c;
            8'h80: seg = 8'hbf;
            8'h81: seg = 8'h86;
            8'h82: seg = 8'hdb;
            8'h83: seg = 8'hcf;
            8'h84: seg = 8'he6;
            8'h85: seg = 8'hed;
            8'h86: seg = 8'hfd;
            8'h87: seg = 8'h87;
            8'h88: seg = 8'hff;
            8'h89: seg = 8'hef;
            8'h8a: seg = 8'hf7;
            8'h8b: seg = 8'hfc;
            8'h8c: seg = 8'hb9;
            8'h8d: seg = 8'hf3;
            8'h8e: seg = 8'hf1;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    function automatic t_chan channel_code(input logic [CODE_W-1:0] ch);
        t_chan c;
        c.ok = 1'b1;
        unique case (ch)
            "1": c.code = 8'h01;
            "2": c.code = 8'h02;
            "3": c.code = 8'h03;
            "4": c.code = 8'h04;
            "5": c.code = 8'h81;
            "6": c.code = 8'h82;
            "7": c.code = 8'h83;
            "8": c.code = 8'h84;
            "A": c.code = 8'h0a;
            "B": c.code = 8'h0b;
            "C": c.code = 8'h0c;
            "P": c.code = 8'h0d;
            "F": c.code = 8'h0e;
            "E": c.code = 8'h0f;
            "a": c.code = 8'h8a;
            "b": c.code = 8'h8b;
            "c": c.code = 8'h8c;
            "p": c.code = 8'h8d;
            "f": c.code = 8'h8e;
            default: begin
                c.ok   = 1'b0;
                c.code = GLYPH_BLANK;
            end
        endcase
        return c;
    endfunction

    // Active-low digit select: position p drives bit (4 - p) low
    function automatic logic [SEL_W-1:0] sel_code(input logic [POS_W-1:0] p);
        logic [SEL_W-1:0] sel;
        unique case (p)
            3'd0:    sel = 5'h0f;
            3'd1:    sel = 5'h17;
            3'd2:    sel = 5'h1b;
            3'd3:    sel = 5'h1d;
            3'd4:    sel = 5'h1e;
            default: sel = 5'h1f;
        endcase
        return sel;
    endfunction

endpackage

// File: rtl/sstd_front.sv
module sstd_front (
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // channel_char[7:0], temp_tenths[23:8], position[26:24], glyph_code[34:27], zero pad
    input  logic [sstd_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // req_type[1:0]
    input  logic [1:0]                          i_s_tuser,
    input  logic [sstd_pkg::MAX_W-1:0]          i_max_shown,
    input  logic signed [sstd_pkg::MIN_W-1:0]   i_min_shown,
    input  logic                                i_full,
    output logic                                o_push,
    output sstd_pkg::t_entry                    o_entry
);
    import sstd_pkg::*;

    logic [CODE_W-1:0]        w_chan_char;
    logic signed [TEMP_W-1:0] w_temp;
    logic [POS_W-1:0]         w_pos;
    logic [CODE_W-1:0]        w_glyph;
    logic [MAX_W-1:0]         w_hi;
    logic signed [MIN_W-1:0]  w_lo;
    logic                     w_pos_ok;
    logic                     w_neg_ok;
    logic signed [TEMP_W-1:0] w_neg_temp;
    t_chan                    w_chan;
    t_req                     w_kind;

    // Unpack the transaction
    assign w_chan_char = i_s_tdata[7:0];
    assign w_temp      = i_s_tdata[23:8];
    assign w_pos       = i_s_tdata[26:24];
    assign w_glyph     = i_s_tdata[34:27];

    // Clamp the shown range to what four positions can hold
    assign w_hi = (i_max_shown > SHOW_MAX_LIMIT) ? SHOW_MAX_LIMIT : i_max_shown;
    assign w_lo = (i_min_shown < SHOW_MIN_LIMIT) ? SHOW_MIN_LIMIT : i_min_shown;

    assign w_pos_ok   = !w_temp[TEMP_W-1] && ({1'b0, w_temp[TEMP_W-2:0]} <= {1'b0, w_hi});
    assign w_neg_ok   = w_temp[TEMP_W-1] && (w_temp >= TEMP_W'(w_lo));
    assign w_neg_temp = -w_temp;
    assign w_chan     = channel_code(w_chan_char);

    // Classify: drop unused request codes and glyph writes off the display
    always_comb begin
        w_kind = t_req'(i_s_tuser);
        if (w_kind == REQ_GLYPH && w_pos >= POS_W'(NUM_POS)) begin
            w_kind = REQ_NONE;
        end
    end

    always_comb begin
        o_entry.kind      = w_kind;
        o_entry.chan_ok   = w_chan.ok;
        o_entry.chan_seg  = glyph_segments(w_chan.code);
        o_entry.oor       = !(w_pos_ok || w_neg_ok);
        o_entry.neg       = w_temp[TEMP_W-1];
        o_entry.mag       = w_temp[TEMP_W-1] ? w_neg_temp[MAG_W-1:0] : w_temp[MAG_W-1:0];
        o_entry.pos       = w_pos;
        o_entry.glyph_seg = glyph_segments(w_glyph);
    end

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full && (w_kind != REQ_NONE);

endmodule

// File: rtl/sstd_queue.sv
module sstd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sstd_pkg::t_entry  i_entry,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output sstd_pkg::t_entry  o_entry
);
    import sstd_pkg::*;

    t_entry     r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rd];

    // Hold entries and advance the pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_entry;
                r_wr        <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/sstd_back.sv
module sstd_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  sstd_pkg::t_entry                     i_entry,
    output logic                                 o_pop,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // segments[7:0], digit_select[12:8], scan_position[15:13]
    output logic [sstd_pkg::OUT_DATA_W-1:0]      o_m_tdata
);
    import sstd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_WRITE
    } t_state;

    t_state                  r_state;
    logic [SEG_W-1:0]        r_buf [NUM_POS];
    logic [POS_W-1:0]        r_ptr;
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;
    logic [MAG_W-1:0]        r_mag;
    logic [1:0]              r_cnt;
    logic [DIG_W-1:0]        r_dig [NUM_DIG];
    logic                    r_neg;
    logic                    r_oor;
    logic                    r_chan_ok;
    logic [SEG_W-1:0]        r_chan_seg;

    logic [POS_W-1:0]        w_p;
    logic [POS_W-1:0]        w_p_next;
    logic                    w_tick_take;
    logic [26:0]             w_prod;
    logic [MAG_W-1:0]        w_qe;
    logic [MAG_W-1:0]        w_rem_raw;
    logic                    w_corr;
    logic [MAG_W-1:0]        w_quot;
    logic [DIG_W-1:0]        w_rem;
    logic [NUM_DIG-1:0]      w_nz;
    logic [CODE_W-1:0]       w_e [NUM_DIG];
    logic [SEG_W-1:0]        w_seg [NUM_DIG];

    // Scan position, wrapping anything past the last position to the first
    assign w_p      = (r_ptr >= POS_W'(NUM_POS)) ? '0 : r_ptr;
    assign w_p_next = (w_p == POS_W'(NUM_POS - 1)) ? '0 : w_p + POS_W'(1);

    // Take the next transaction; a tick waits for a free output slot
    always_comb begin
        o_pop = 1'b0;
        if (r_state == S_IDLE && i_valid) begin
            if (i_entry.kind == REQ_TICK) begin
                o_pop = !r_out_valid || i_m_tready;
            end else begin
                o_pop = 1'b1;
            end
        end
    end

    assign w_tick_take = o_pop && (i_entry.kind == REQ_TICK);

    // One decimal digit per cycle: estimate quotient by reciprocal, then correct once
    assign w_prod    = 27'(r_mag) * 27'(RECIP_TEN);
    assign w_qe      = MAG_W'(w_prod[26:RECIP_SHIFT]);
    assign w_rem_raw = r_mag - ((w_qe << 3) + (w_qe << 1));
    assign w_corr    = (w_rem_raw >= MAG_W'(10));
    assign w_quot    = w_qe + MAG_W'(w_corr);
    assign w_rem     = w_corr ? DIG_W'(w_rem_raw - MAG_W'(10)) : DIG_W'(w_rem_raw);

    // Lay out the digits with minus sign, dot, leading-zero blanking and out-of-range dashes
    always_comb begin
        for (int i = 0; i < NUM_DIG; i++) begin
            w_nz[i] = (r_dig[i] != '0);
            w_e[i]  = {4'b0, r_dig[i]};
        end
        if (r_oor) begin
            for (int i = 0; i < NUM_DIG; i++) begin
                w_e[i] = GLYPH_MINUS;
            end
        end else if (r_neg) begin
            if (w_nz[2] || w_nz[3]) begin
                w_e[3] = GLYPH_MINUS;
            end else begin
                w_e[2] = GLYPH_MINUS;
            end
        end
        w_seg[0] = glyph_segments((!(|w_nz) && w_e[0] == '0) ? GLYPH_BLANK : w_e[0]);
        w_seg[1] = glyph_segments(r_oor ? GLYPH_MINUS : (DOT_FLAG | w_e[1]));
        w_seg[2] = glyph_segments((!(w_nz[2] || w_nz[3]) && w_e[2] == '0) ?
                                  GLYPH_BLANK : w_e[2]);
        w_seg[3] = glyph_segments((!w_nz[3] && w_e[3] == '0) ? GLYPH_BLANK : w_e[3]);
    end

    // Sequence requests, hold the display buffer and the output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_buf[0]    <= 8'h00;
            r_buf[1]    <= 8'h0f;
            r_buf[2]    <= 8'h09;
            r_buf[3]    <= 8'h09;
            r_buf[4]    <= 8'h39;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && !w_tick_take) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (i_entry.kind)
                            REQ_TICK: begin
                                r_out_valid <= 1'b1;
                                r_out_data  <= {w_p, sel_code(w_p), r_buf[w_p]};
                                r_ptr       <= w_p_next;
                            end
                            REQ_GLYPH: begin
                                r_buf[i_entry.pos] <= i_entry.glyph_seg;
                            end
                            REQ_TEMP: begin
                                r_mag      <= i_entry.mag;
                                r_neg      <= i_entry.neg;
                                r_oor      <= i_entry.oor;
                                r_chan_ok  <= i_entry.chan_ok;
                                r_chan_seg <= i_entry.chan_seg;
                                r_cnt      <= '0;
                                r_state    <= S_CONV;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CONV: begin
                    r_dig[r_cnt] <= w_rem;
                    r_mag        <= w_quot;
                    r_cnt        <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (r_chan_ok) begin
                        r_buf[0] <= r_chan_seg;
                    end
                    r_buf[1] <= w_seg[0];
                    r_buf[2] <= w_seg[1];
                    r_buf[3] <= w_seg[2];
                    r_buf[4] <= w_seg[3];
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// File: rtl/seven_segment_temperature_display_unit.sv
// Five-position multiplexed seven-segment driver with temperature layout.
// A scan tick passes through the two-entry queue and its result is registered in the output
// slot; a temperature request ahead of it delays it while its digits are converted.
// The back end handles one request at a time and takes no new one while it converts a
// temperature; its divide-by-ten unit yields one decimal digit a cycle.
// Synchronous active-low reset restores the power-up pattern, scan pointer and registers.
module seven_segment_temperature_display_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // channel_char[7:0], temp_tenths[23:8], position[26:24], glyph_code[34:27], zero pad
    input  logic [sstd_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // req_type[1:0]
    input  logic [1:0]                           i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // segments[7:0], digit_select[12:8], scan_position[15:13]
    output logic [sstd_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import sstd_pkg::*;

    logic [MAX_W-1:0]        r_max_shown;
    logic signed [MIN_W-1:0] r_min_shown;
    logic                    w_push;
    logic                    w_full;
    logic                    w_q_valid;
    logic                    w_pop;
    t_entry                  w_in_entry;
    t_entry                  w_q_entry;

    // Configuration registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_shown <= SHOW_MAX_LIMIT;
            r_min_shown <= SHOW_MIN_LIMIT;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_MAX_SHOWN: r_max_shown <= pwdata[MAX_W-1:0];
                REG_MIN_SHOWN: r_min_shown <= pwdata[MIN_W-1:0];
                default:       r_max_shown <= r_max_shown;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAX_SHOWN: prdata = {{(32 - MAX_W){1'b0}}, r_max_shown};
            REG_MIN_SHOWN: prdata = {{(32 - MIN_W){1'b0}}, r_min_shown};
            default:       prdata = '0;
        endcase
    end

    sstd_front u_front (
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_max_shown (r_max_shown),
        .i_min_shown (r_min_shown),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_entry     (w_in_entry)
    );

    sstd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_entry (w_q_entry)
    );

    sstd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_entry    (w_q_entry),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// File: sim/seven_segment_temperature_display_unit_tb.sv
`timescale 1ns / 100ps

module seven_segment_temperature_display_unit_tb;
    import sstd_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_OFF    = 32;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_ITEMS = 245;
    localparam int NUM_PHASES  = 7;
    localparam int REPORT_MAX  = 10;

    // Display behaviour: segment store, scan pointer, shown range and pending scan outputs
    class segment_display_model;
        logic [SEG_W-1:0]        seg_buf [NUM_POS];
        logic [POS_W-1:0]        scan_ptr;
        logic [MAX_W-1:0]        max_shown;
        logic signed [MIN_W-1:0] min_shown;
        logic [OUT_DATA_W-1:0]   pending_scans [$];
        int                      failures;

        function new();
            seg_buf   = '{8'h00, 8'h0f, 8'h09, 8'h09, 8'h39};
            scan_ptr  = '0;
            max_shown = 14'd9999;
            min_shown = -11'sd999;
            failures  = 0;
        endfunction

        function logic [SEG_W-1:0] digit_segs(int d);
            case (d)
                0: return 8'h3f;
                1: return 8'h06;
                2: return 8'h5b;
                3: return 8'h4f;
                4: return 8'h66;
                5: return 8'h6d;
                6: return 8'h7d;
                7: return 8'h07;
                8: return 8'h7f;
                default: return 8'h6f;
            endcase
        endfunction

        // Letters A b C P F E, then the dotted A b C P F
        function logic [SEG_W-1:0] letter_segs(int l);
            case (l)
                0: return 8'h77;
                1: return 8'h7c;
                2: return 8'h39;
                3: return 8'h73;
                4: return 8'h71;
                5: return 8'h79;
                6: return 8'hf7;
                7: return 8'hfc;
                8: return 8'hb9;
                9: return 8'hf3;
                default: return 8'hf1;
            endcase
        endfunction

        function logic [SEG_W-1:0] segments_for(int code);
            if (code < 10) return digit_segs(code);
            if (code < 16) return letter_segs(code - 10);
            if (code == GLYPH_BLANK) return 8'h00;
            if (code == GLYPH_MINUS) return 8'h40;
            if (code == GLYPH_MINUS + 1) return 8'h50;
            if (code == GLYPH_MINUS + 2) return 8'h5c;
            if (code >= DOT_FLAG && code < DOT_FLAG + 10)
                return digit_segs(code - DOT_FLAG) | DOT_FLAG;
            if (code >= DOT_FLAG + 10 && code < DOT_FLAG + 15)
                return letter_segs(code - DOT_FLAG - 4);
            return 8'h00;
        endfunction

        // Glyph code of a channel label, or -1 for an unknown label
        function int channel_glyph(logic [7:0] ch);
            case (ch)
                "1": return 1;
                "2": return 2;
                "3": return 3;
                "4": return 4;
                "5": return DOT_FLAG + 1;
                "6": return DOT_FLAG + 2;
                "7": return DOT_FLAG + 3;
                "8": return DOT_FLAG + 4;
                "A": return 10;
                "B": return 11;
                "C": return 12;
                "P": return 13;
                "F": return 14;
                "E": return 15;
                "a": return DOT_FLAG + 10;
                "b": return DOT_FLAG + 11;
                "c": return DOT_FLAG + 12;
                "p": return DOT_FLAG + 13;
                "f": return DOT_FLAG + 14;
                default: return -1;
            endcase
        endfunction

        function void show_temperature(logic [7:0] ch, int value);
            int dig [4];
            int size;
            int mag;
            int hi;
            int lo;
            int cc;
            int i;
            bit oor;
            dig  = '{0, 0, 0, 0};
            size = 0;
            oor  = 1'b0;
            hi   = int'(max_shown);
            lo   = int'(min_shown);
            if (hi > 9999) hi = 9999;
            if (lo < -999) lo = -999;
            if (value >= 0 && value <= hi) begin
                mag = value;
                while (mag != 0 && size < 4) begin
                    dig[size] = mag % 10;
                    mag = mag / 10;
                    size++;
                end
            end else if (value < 0 && value >= lo) begin
                mag = -value;
                while (mag != 0 && size < 4) begin
                    dig[size] = mag % 10;
                    mag = mag / 10;
                    size++;
                end
                // Minus goes just above the digits
                if (size > 2) dig[3] = GLYPH_MINUS;
                else dig[2] = GLYPH_MINUS;
            end else begin
                oor = 1'b1;
                for (i = 0; i < 4; i++) dig[i] = GLYPH_MINUS;
            end
            cc = channel_glyph(ch);
            if (cc >= 0) seg_buf[0] = segments_for(cc);
            for (i = 0; i < 4; i++) begin
                if (i == 1)
                    seg_buf[2] = segments_for(oor ? dig[1] : dig[1] + DOT_FLAG);
                else if (i + 1 > size && dig[i] == 0)
                    seg_buf[i + 1] = segments_for(GLYPH_BLANK);
                else
                    seg_buf[i + 1] = segments_for(dig[i]);
            end
        endfunction

        function void set_register(logic reg_sel, logic [31:0] value);
            if (reg_sel == REG_MAX_SHOWN) max_shown = value[MAX_W-1:0];
            else min_shown = $signed(value[MIN_W-1:0]);
        endfunction

        // Apply one accepted request; a scan tick queues its output
        function void accept_request(t_req kind, logic [7:0] ch, logic [15:0] temp,
                                     logic [POS_W-1:0] pos, logic [CODE_W-1:0] code);
            logic [POS_W-1:0] p;
            logic [SEL_W-1:0] sel;
            case (kind)
                REQ_TICK: begin
                    p = (scan_ptr >= NUM_POS) ? '0 : scan_ptr;
                    sel = 5'h1f & ~(5'd1 << (4 - p));
                    pending_scans.push_back({p, sel, seg_buf[p]});
                    scan_ptr = (p + 1 >= NUM_POS) ? '0 : POS_W'(p + 1);
                end
                REQ_TEMP: show_temperature(ch, int'($signed(temp)));
                REQ_GLYPH: begin
                    if (pos < NUM_POS) seg_buf[pos] = segments_for(code);
                end
                default: ;
            endcase
        endfunction

        function void check_scan(logic [OUT_DATA_W-1:0] got);
            logic [OUT_DATA_W-1:0] want;
            if (pending_scans.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected scan output: seg %02h sel %02h pos %0d",
                             got[7:0], got[12:8], got[15:13]);
                return;
            end
            want = pending_scans.pop_front();
            if (got[7:0] !== want[7:0] || got[12:8] !== want[12:8]
                    || got[15:13] !== want[15:13]) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display({"scan mismatch: expected seg %02h sel %02h pos %0d, ",
                              "got seg %02h sel %02h pos %0d"},
                             want[7:0], want[12:8], want[15:13],
                             got[7:0], got[12:8], got[15:13]);
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [IN_DATA_W-1:0]    i_s_tdata = '0;
    logic [1:0]              i_s_tuser = REQ_TICK;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   o_m_tdata;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [2:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    segment_display_model display = new();
    string channel_labels = "12345678ABCPFEabcpf";
    bit    sender_calm = 1'b0;
    bit    receiver_calm = 1'b0;
    int    stall_left = 0;
    int    idle_cycles = 0;

    seven_segment_temperature_display_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Idle lengths: mostly short, a few long, with calm stretches of none
    function int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function int sender_gap();
        if ($urandom_range(0, 99) < 3) sender_calm = ~sender_calm;
        if (sender_calm) return 0;
        return gap_length();
    endfunction

    // Drive the receiver's ready with random stalls
    initial begin
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 99) < 2) receiver_calm = ~receiver_calm;
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else if (!receiver_calm && $urandom_range(0, 99) < 25) begin
                stall_left = gap_length();
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
            @(negedge i_clk);
        end
    end

    // Check each scan output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) display.check_scan(o_m_tdata);
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("seven_segment_temperature_display_unit verification failed");
            $finish;
        end
    end

    task automatic write_register(logic reg_sel, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        display.set_register(reg_sel, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Send one request, hold it until accepted, then idle for a random gap
    task automatic issue_request(t_req kind, logic [7:0] ch, logic [15:0] temp,
                                 logic [POS_W-1:0] pos, logic [CODE_W-1:0] code);
        int n;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {5'b0, code, pos, temp, ch};
        do @(posedge i_clk); while (!o_s_tready);
        display.accept_request(kind, ch, temp, pos, code);
        n = sender_gap();
        if (n > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= IN_DATA_W'({$urandom, $urandom});
            i_s_tuser  <= 2'($urandom_range(0, 3));
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid and wait for every pending scan output, then let the back end settle
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (display.pending_scans.size() != 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    function logic [15:0] pick_temp();
        int hi;
        int lo;
        int v;
        int r;
        hi = int'(display.max_shown);
        lo = int'(display.min_shown);
        if (hi > 9999) hi = 9999;
        if (lo < -999) lo = -999;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            v = lo + int'($urandom_range(0, hi - lo));
        end else if (r < 55) begin
            case ($urandom_range(0, 20))
                0: v = hi;
                1: v = hi + 1;
                2: v = lo;
                3: v = lo - 1;
                4: v = 0;
                5: v = 1;
                6: v = -1;
                7: v = 9;
                8: v = 10;
                9: v = -9;
                10: v = -10;
                11: v = 99;
                12: v = 100;
                13: v = -99;
                14: v = -100;
                15: v = 999;
                16: v = 1000;
                17: v = hi - 1;
                18: v = lo + 1;
                19: v = -32768;
                default: v = 32767;
            endcase
        end else if (r < 75) begin
            v = int'($urandom_range(0, 65535));
        end else begin
            v = int'($urandom_range(0, 300)) - 150;
        end
        return v[15:0];
    endfunction

    function logic [7:0] pick_channel();
        if ($urandom_range(0, 99) < 75)
            return channel_labels[$urandom_range(0, channel_labels.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    function logic [CODE_W-1:0] pick_glyph();
        int idx;
        if ($urandom_range(0, 99) < 70) begin
            idx = $urandom_range(0, 34);
            if (idx < 20) return CODE_W'(idx);
            return CODE_W'(DOT_FLAG + idx - 20);
        end
        return CODE_W'($urandom_range(0, 255));
    endfunction

    function logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, NUM_POS - 1));
        return POS_W'($urandom_range(NUM_POS, 7));
    endfunction

    task automatic random_requests(int count);
        int r;
        t_req kind;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 45) kind = REQ_TICK;
            else if (r < 70) kind = REQ_TEMP;
            else if (r < 95) kind = REQ_GLYPH;
            else kind = REQ_NONE;
            issue_request(kind, pick_channel(), pick_temp(), pick_position(), pick_glyph());
        end
    endtask

    task automatic directed_requests();
        // Power-up pattern and every select, then the wrap
        repeat (6) issue_request(REQ_TICK, 8'h00, 16'h0000, 3'd0, 8'h00);
        // Zero, range limits, out of range, unknown label, full-scale inputs
        issue_request(REQ_TEMP, "1", 16'd0, 3'd0, 8'h00);
        issue_request(REQ_TEMP, "p", -16'sd999, 3'd0, 8'h00);
        issue_request(REQ_TEMP, "5", 16'd9999, 3'd0, 8'h00);
        issue_request(REQ_TEMP, "E", -16'sd5, 3'd0, 8'h00);
        issue_request(REQ_TEMP, "c", 16'd10000, 3'd0, 8'h00);
        issue_request(REQ_TEMP, 8'hc3, -16'sd1000, 3'd7, 8'hff);
        issue_request(REQ_TEMP, "A", 16'h8000, 3'd0, 8'h00);
        issue_request(REQ_TEMP, "f", 16'h7fff, 3'd0, 8'h00);
        // Unknown glyphs, positions beyond the display, ignored request type
        issue_request(REQ_GLYPH, 8'h00, 16'h0000, 3'd4, 8'h8f);
        issue_request(REQ_GLYPH, 8'h00, 16'h0000, 3'd3, 8'hff);
        issue_request(REQ_GLYPH, 8'h00, 16'h0000, 3'd5, 8'h88);
        issue_request(REQ_GLYPH, 8'h00, 16'h0000, 3'd7, GLYPH_MINUS + 8'd2);
        issue_request(REQ_GLYPH, 8'hff, 16'hffff, 3'd1, 8'h8e);
        issue_request(REQ_NONE, 8'hff, 16'hffff, 3'd7, 8'hff);
        repeat (5) issue_request(REQ_TICK, 8'hff, 16'hffff, 3'd7, 8'hff);
    endtask

    initial begin
        logic [MAX_W-1:0]        max_tab [NUM_PHASES];
        logic signed [MIN_W-1:0] min_tab [NUM_PHASES];
        int ph;
        max_tab = '{14'd9999, 14'd0, 14'd16383, 14'd1234, 14'd0, 14'd0, 14'd9999};
        min_tab = '{-11'sd999, 11'sd0, -11'sd1024, -11'sd56, 11'sd0, 11'sd0, -11'sd1};
        max_tab[4] = MAX_W'($urandom_range(0, 9999));
        max_tab[5] = MAX_W'($urandom_range(0, 9999));
        min_tab[4] = -$signed(11'($urandom_range(0, 999)));
        min_tab[5] = -$signed(11'($urandom_range(0, 999)));

        // Hold reset, then release
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_requests();
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            write_register(REG_MAX_SHOWN, {18'b0, max_tab[ph]});
            write_register(REG_MIN_SHOWN, {21'b0, min_tab[ph]});
            random_requests(PHASE_ITEMS);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (display.failures == 0 && display.pending_scans.size() == 0) begin
            $display("seven_segment_temperature_display_unit verification clean");
        end else begin
            $display("seven_segment_temperature_display_unit verification failed");
        end
        $finish;
    end

endmodule
